// ===== hdl/gdbrsp_pkg.sv =====
// Shared types, codes and a helper function for the GDB remote-protocol packet framer.
`default_nettype none

package gdbrsp_pkg;

	localparam logic [1:0] CMD_RECV  = 2'd0;
	localparam logic [1:0] CMD_FIN   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_BREAK  = 8'h03;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [3:0] NIBBLE_MASK = 4'hf;

	// Step of a finalize that emits the low checksum digit.
	localparam logic [1:0] FIN_LAST = 2'd2;

	typedef enum logic [1:0] {OP_BYTE, OP_FIN, OP_CLEAR, OP_NOP} op_t;
	typedef enum logic [1:0] {PH_WAIT, PH_PAY, PH_CHK, PH_DONE} phase_t;
	typedef enum logic [2:0] {K_INVALID, K_DATA, K_ACK, K_NAK, K_BREAK} kind_t;
	typedef enum logic [1:0] {R_NONE, R_PAYLOAD, R_FRAME, R_CHECK} role_t;

	// One classified request as it waits in the queue.
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       is_hash;
		kind_t      start_kind;
		logic       hex_ok;
		logic [3:0] nibble;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		role_t      role;
		logic       acc;
		phase_t     phase;
		kind_t      kind;
		logic       done;
		logic [7:0] calc;
		logic [7:0] recv;
		logic       match;
		logic       hex_err;
		logic       last;
	} result_t;

	// Lowercase hex character for a nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10)
			r = 8'h30 + {4'd0, n};
		else
			r = 8'h57 + {4'd0, n};
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/gdbrsp_front.sv =====
// Front end: decodes the command and classifies the received byte.
`default_nettype none

module gdbrsp_front (
	input  wire logic [1:0]        cmd,
	input  wire logic [7:0]        in_byte,
	output gdbrsp_pkg::item_t      item
);
	import gdbrsp_pkg::*;

	logic [7:0] dec_sub;

	always_comb begin
		item = '0;
		item.data = in_byte;
		unique case (cmd)
			CMD_RECV:  item.op = OP_BYTE;
			CMD_FIN:   item.op = OP_FIN;
			CMD_CLEAR: item.op = OP_CLEAR;
			default:   item.op = OP_NOP;
		endcase

		item.is_hash = (in_byte == CH_HASH);
		if (in_byte == CH_DOLLAR)
			item.start_kind = K_DATA;
		else if (in_byte == CH_PLUS)
			item.start_kind = K_ACK;
		else if (in_byte == CH_MINUS)
			item.start_kind = K_NAK;
		else if (in_byte == CH_BREAK)
			item.start_kind = K_BREAK;
		else
			item.start_kind = K_INVALID;

		// An invalid character decodes as nibble zero.
		dec_sub = 8'd0;
		item.hex_ok = 1'b1;
		if (in_byte >= 8'h30 && in_byte <= 8'h39)
			dec_sub = in_byte - 8'h30;
		else if (in_byte >= 8'h61 && in_byte <= 8'h66)
			dec_sub = in_byte - 8'h57;
		else if (in_byte >= 8'h41 && in_byte <= 8'h46)
			dec_sub = in_byte - 8'h37;
		else
			item.hex_ok = 1'b0;
		item.nibble = dec_sub[3:0] & NIBBLE_MASK;
	end

endmodule

`default_nettype wire

// ===== hdl/gdbrsp_queue.sv =====
// Two-entry request queue between the front end and the packet engine.
`default_nettype none

module gdbrsp_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire gdbrsp_pkg::item_t push_item,
	input  wire logic              pop,
	output logic                   full,
	output logic                   head_valid,
	output gdbrsp_pkg::item_t      head
);
	import gdbrsp_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	logic do_push;
	logic do_pop;

	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;
	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

// ===== hdl/gdbrsp_back.sv =====
// Packet engine: runs the framing state and registers one result per cycle unless the output stalls.
`default_nettype none

module gdbrsp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire gdbrsp_pkg::item_t head,
	output logic                   pop,
	output logic                   res_valid,
	output gdbrsp_pkg::result_t    res,
	input  wire logic              res_ready
);
	import gdbrsp_pkg::*;

	phase_t     phase_q;
	kind_t      kind_q;
	logic [7:0] sum_q;
	logic [1:0] trail_q;
	logic [3:0] high_q;
	logic       hexbad_q;
	logic [1:0] fin_q;
	logic       res_valid_q;
	result_t    res_q;

	phase_t     phase_n;
	kind_t      kind_n;
	logic [7:0] sum_n;
	logic [1:0] trail_n;
	logic [3:0] high_n;
	logic       hexbad_n;
	logic [1:0] fin_n;
	logic       adv;
	logic       load;
	logic       take;
	item_t      cls;
	logic [3:0] fin_nib;
	result_t    res_n;

	assign adv       = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		phase_n  = phase_q;
		kind_n   = kind_q;
		sum_n    = sum_q;
		trail_n  = trail_q;
		high_n   = high_q;
		hexbad_n = hexbad_q;
		fin_n    = fin_q;
		pop      = 1'b0;
		load     = 1'b0;
		take     = 1'b0;
		cls      = head;
		res_n    = '0;
		res_n.last = 1'b1;
		fin_nib  = (fin_q == FIN_LAST) ? sum_q[3:0] : sum_q[7:4];

		if (head_valid && adv) begin
			load = 1'b1;
			unique case (head.op)
				OP_BYTE: begin
					take = 1'b1;
					pop  = 1'b1;
				end
				OP_FIN: begin
					if (fin_q == 2'd0 && !(phase_q == PH_PAY && kind_q == K_DATA)) begin
						pop = 1'b1;
					end else begin
						// Finalize feeds '#' and then the two digits of the sum.
						take = 1'b1;
						cls  = '0;
						cls.op = OP_BYTE;
						if (fin_q == 2'd0) begin
							cls.data    = CH_HASH;
							cls.is_hash = 1'b1;
						end else begin
							cls.data   = hex_char(fin_nib);
							cls.hex_ok = 1'b1;
							cls.nibble = fin_nib;
						end
						res_n.last = (fin_q == FIN_LAST);
						pop        = (fin_q == FIN_LAST);
						fin_n      = (fin_q == FIN_LAST) ? 2'd0 : fin_q + 2'd1;
					end
				end
				OP_CLEAR: begin
					pop       = 1'b1;
					res_n.acc = 1'b1;
					phase_n   = PH_WAIT;
					kind_n    = K_INVALID;
					sum_n     = 8'd0;
					trail_n   = 2'd0;
					high_n    = 4'd0;
					hexbad_n  = 1'b0;
				end
				default: begin
					pop = 1'b1;
				end
			endcase
		end

		if (take) begin
			unique case (phase_q)
				PH_WAIT: begin
					if (cls.start_kind != K_INVALID) begin
						kind_n  = cls.start_kind;
						phase_n = (cls.start_kind == K_DATA) ? PH_PAY : PH_DONE;
						if (cls.start_kind == K_DATA)
							sum_n = 8'd0;
						res_n.out_byte = cls.data;
						res_n.role     = R_FRAME;
						res_n.acc      = 1'b1;
						res_n.done     = (cls.start_kind != K_DATA);
					end
				end
				PH_PAY: begin
					res_n.out_byte = cls.data;
					res_n.acc      = 1'b1;
					if (cls.is_hash) begin
						phase_n    = PH_CHK;
						trail_n    = 2'd0;
						res_n.role = R_FRAME;
					end else begin
						sum_n      = sum_q + cls.data;
						res_n.role = R_PAYLOAD;
					end
				end
				PH_CHK: begin
					res_n.out_byte = cls.data;
					res_n.acc      = 1'b1;
					res_n.role     = R_CHECK;
					if (!cls.hex_ok)
						hexbad_n = 1'b1;
					if (trail_q == 2'd0) begin
						high_n  = cls.nibble;
						trail_n = 2'd1;
					end else begin
						trail_n     = 2'd2;
						phase_n     = PH_DONE;
						res_n.done  = 1'b1;
						res_n.recv  = {high_q, cls.nibble};
						res_n.match = ({high_q, cls.nibble} == sum_q) && !hexbad_n;
					end
				end
				default: begin
				end
			endcase
		end

		res_n.phase   = phase_n;
		res_n.kind    = kind_n;
		res_n.calc    = sum_n;
		res_n.hex_err = hexbad_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			kind_q      <= K_INVALID;
			sum_q       <= 8'd0;
			trail_q     <= 2'd0;
			high_q      <= 4'd0;
			hexbad_q    <= 1'b0;
			fin_q       <= 2'd0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			kind_q   <= kind_n;
			sum_q    <= sum_n;
			trail_q  <= trail_n;
			high_q   <= high_n;
			hexbad_q <= hexbad_n;
			fin_q    <= fin_n;
			if (load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_n;
	end

	// A finalize in flight keeps its request at the head of the queue.
	a_fin_head: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q != 2'd0 |-> head_valid && head.op == OP_FIN)
		else $error("finalize sequence without its request at the queue head");

	a_fin_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q != 2'd0 |-> phase_q == PH_CHK && kind_q == K_DATA)
		else $error("finalize sequence outside the checksum phase");

	a_fin_range: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q != 2'd3)
		else $error("finalize step counter out of range");

	a_hexbad_phase: assert property (@(posedge clk) disable iff (!arst_n)
		hexbad_q |-> phase_q == PH_CHK || phase_q == PH_DONE)
		else $error("hex error flag set outside the trailer");

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done |-> res_q.phase == PH_DONE && res_q.acc)
		else $error("completion reported while the packet is not complete");

endmodule

`default_nettype wire

// ===== hdl/gdb_rsp_packet_framer.sv =====
// A request is registered in the queue, and its result then in the result register.
// The engine takes one request per cycle unless the output stalls; a finalize that is
// taken stays at the queue head until '#' and both digits are emitted, one result each.
// The input sees a two-entry queue, so it keeps accepting while a result waits, until full.
// Reset (arst_n low, asynchronous) empties the queue and the result register and returns
// the framer to waiting for a start byte with all sums and flags cleared.
`default_nettype none

module gdb_rsp_packet_framer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] cmd,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic [1:0]      out_role,
	output logic            accepted,
	output logic [1:0]      phase,
	output logic [2:0]      packet_type,
	output logic            done_res,
	output logic [7:0]      calc_sum,
	output logic [7:0]      recv_sum,
	output logic            sum_match,
	output logic            hex_error,
	output logic            last
);
	import gdbrsp_pkg::*;

	item_t   fe_item;
	item_t   q_head;
	logic    q_full;
	logic    q_valid;
	logic    q_pop;
	result_t res;

	assign in_ready = !q_full;

	gdbrsp_front u_front (
		.cmd     (cmd),
		.in_byte (in_byte),
		.item    (fe_item)
	);

	gdbrsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid),
		.push_item  (fe_item),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head       (q_head)
	);

	gdbrsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.res_valid  (out_valid),
		.res        (res),
		.res_ready  (out_ready)
	);

	assign out_byte    = res.out_byte;
	assign out_role    = res.role;
	assign accepted    = res.acc;
	assign phase       = res.phase;
	assign packet_type = res.kind;
	assign done_res    = res.done;
	assign calc_sum    = res.calc;
	assign recv_sum    = res.recv;
	assign sum_match   = res.match;
	assign hex_error   = res.hex_err;
	assign last        = res.last;

endmodule

`default_nettype wire
